FILE: src/twzp_pkg.sv
// Package for the timeline window zoom/pan core.
// Holds stream word widths, field offsets and the command codes.
// No dependencies.
package twzp_pkg;

	localparam int POS_BITS_DEF = 64;

	// Slave word field layout, lowest bit first.
	localparam int S_DATA_W = 448;
	localparam int S_USER_W = 3;
	localparam int OFF_DOM  = 0;
	localparam int OFF_AN   = 64;
	localparam int OFF_AD   = 96;
	localparam int OFF_SN   = 128;
	localparam int OFF_SD   = 160;
	localparam int OFF_PAN  = 192;
	localparam int OFF_RB   = 256;
	localparam int OFF_RE   = 320;
	localparam int OFF_MG   = 384;

	// Master word layout: accepted, out_valid, out_begin, out_end, zero fill.
	localparam int M_DATA_W = 136;
	localparam int M_USED_W = 130;

	typedef enum logic [2:0] {
		KIND_FIT   = 3'd0,
		KIND_ZOOM  = 3'd1,
		KIND_PAN   = 3'd2,
		KIND_FOCUS = 3'd3,
		KIND_CLEAR = 3'd4
	} kind_t;

endpackage

FILE: src/timeline_window_zoom_pan_core.sv
// Timeline window zoom/pan core: view window state plus one shared
// multiply/divide unit for zoom. Depends on twzp_pkg.
//
// Channel  Dir  Signals                     Contents
// s        in   s_tvalid s_tready s_tdata   command word, kind in s_tuser
//                s_tuser
// m        out  m_tvalid m_tready m_tdata   result word
//
// Fit, pan, focus, clear and rejected commands pass from accept through the
// execute state to the done state. A zoom runs the shared unit three times
// (span scale, old anchor offset, new anchor offset), each a multiply and a
// divide (two quotient bits a cycle), then the placement states before done.
// A new word is taken only in idle; a result held by m_tready low stalls
// the next command in the done state. Reset clears the window to invalid.
module timeline_window_zoom_pan_core #(
	parameter int POS_BITS = twzp_pkg::POS_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// new_domain_end, anchor_num, anchor_den, scale_num, scale_den,
	// pan_delta, range_begin, range_end, margin
	input  logic [twzp_pkg::S_DATA_W-1:0] s_tdata,
	// kind
	input  logic [twzp_pkg::S_USER_W-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// accepted, out_valid, out_begin, out_end, zero fill
	output logic [twzp_pkg::M_DATA_W-1:0] m_tdata
);
	import twzp_pkg::*;

	localparam int MUL_STEPS  = 32;
	localparam int DIV_CYCLES = 48;

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXEC, ST_MUL, ST_DIV, ST_POST, ST_ZF1, ST_ZF2, ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		PASS_SCALE, PASS_OLD, PASS_NEW
	} pass_t;

	state_t              state_q;
	logic [2:0]          kind_q;
	logic [63:0]         dom_q, delta_q, rb_q, re_q, mg_q;
	logic [31:0]         an_q, ad_q, sn_q, sd_q;
	logic                flag_q, ok_q;
	logic [POS_BITS-1:0] limit_q, start_q, stop_q;
	logic [POS_BITS-1:0] ns_q, offold_q, off_q, anchor_q, lim_q;
	logic [95:0]         mul_q;
	logic [32:0]         rem_q;
	logic [5:0]          cnt_q;
	pass_t               op_q;
	logic                mvalid_q;
	logic [M_USED_W-1:0] mdata_q;

	logic [63:0] lim64, st64, sp64, span64;
	logic        usable, zoom_ok;
	assign lim64  = 64'(limit_q);
	assign st64   = 64'(start_q);
	assign sp64   = 64'(stop_q);
	assign span64 = sp64 - st64;
	assign usable = flag_q && (limit_q != '0) && (start_q < stop_q) && (stop_q <= limit_q);
	assign zoom_ok = usable && (ad_q != '0) && (an_q <= ad_q) && (sn_q != '0) && (sd_q != '0);

	// Operands of the shared unit for the current pass.
	logic [63:0] u_v;
	logic [31:0] u_d;
	always_comb begin
		u_v = (op_q == PASS_NEW) ? 64'(ns_q) : span64;
		u_d = (op_q == PASS_SCALE) ? sd_q : ad_q;
	end

	// Multiply step: right-shift add of the multiplicand into the top.
	logic [64:0] mul_sum;
	assign mul_sum = {1'b0, mul_q[95:32]} + (mul_q[0] ? {1'b0, u_v} : 65'd0);

	// Divide: two restoring steps a cycle.
	logic [32:0] dv_r;
	logic [95:0] dv_q;
	always_comb begin
		dv_r = rem_q;
		dv_q = mul_q;
		for (int i = 0; i < 2; i++) begin
			dv_r = {dv_r[31:0], dv_q[95]};
			dv_q = {dv_q[94:0], 1'b0};
			if (dv_r >= {1'b0, u_d}) begin
				dv_r = dv_r - {1'b0, u_d};
				dv_q[0] = 1'b1;
			end
		end
	end

	// Ceiling with saturation, then clamp to [1, limit].
	logic [63:0] ceil64, ns64;
	logic        inc;
	always_comb begin
		inc = (rem_q[31:0] != '0);
		if ((mul_q[95:64] != '0) || ((mul_q[63:0] == '1) && inc))
			ceil64 = '1;
		else
			ceil64 = mul_q[63:0] + 64'(inc);
		ns64 = ceil64;
		if (ns64 == '0)
			ns64 = 64'd1;
		if (ns64 > lim64)
			ns64 = lim64;
	end

	// Pan.
	logic [63:0] maxb, mag, pan_nb;
	always_comb begin
		maxb = lim64 - span64;
		mag  = delta_q[63] ? (~delta_q + 64'd1) : delta_q;
		if (!delta_q[63])
			pan_nb = (mag >= maxb - st64) ? maxb : st64 + mag;
		else
			pan_nb = (mag >= st64) ? 64'd0 : st64 - mag;
	end

	// Focus.
	logic [63:0] lm1, fb, fe, frem, f_st, f_sp;
	always_comb begin
		lm1  = lim64 - 64'd1;
		fb   = (rb_q < lm1) ? rb_q : lm1;
		fe   = (re_q < lim64) ? re_q : lim64;
		if (fe <= fb)
			fe = fb + 64'd1;
		frem = lim64 - fe;
		f_st = (mg_q > fb) ? 64'd0 : fb - mg_q;
		f_sp = (mg_q >= frem) ? lim64 : fe + mg_q;
	end

	// Zoom placement.
	logic [POS_BITS-1:0] z_nb;
	always_comb begin
		z_nb = (anchor_q >= off_q) ? anchor_q - off_q : '0;
		if (z_nb > lim_q)
			z_nb = lim_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			kind_q   <= '0;
			dom_q    <= '0;
			delta_q  <= '0;
			rb_q     <= '0;
			re_q     <= '0;
			mg_q     <= '0;
			an_q     <= '0;
			ad_q     <= '0;
			sn_q     <= '0;
			sd_q     <= '0;
			flag_q   <= 1'b0;
			ok_q     <= 1'b0;
			limit_q  <= '0;
			start_q  <= '0;
			stop_q   <= '0;
			ns_q     <= '0;
			offold_q <= '0;
			off_q    <= '0;
			anchor_q <= '0;
			lim_q    <= '0;
			mul_q    <= '0;
			rem_q    <= '0;
			cnt_q    <= '0;
			op_q     <= PASS_SCALE;
			mvalid_q <= 1'b0;
			mdata_q  <= '0;
		end else begin
			// In the done state the output register is reloaded instead.
			if (mvalid_q && m_tready && (state_q != ST_DONE))
				mvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						kind_q  <= s_tuser;
						dom_q   <= s_tdata[OFF_DOM +: 64];
						an_q    <= s_tdata[OFF_AN +: 32];
						ad_q    <= s_tdata[OFF_AD +: 32];
						sn_q    <= s_tdata[OFF_SN +: 32];
						sd_q    <= s_tdata[OFF_SD +: 32];
						delta_q <= s_tdata[OFF_PAN +: 64];
						rb_q    <= s_tdata[OFF_RB +: 64];
						re_q    <= s_tdata[OFF_RE +: 64];
						mg_q    <= s_tdata[OFF_MG +: 64];
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					ok_q    <= 1'b0;
					state_q <= ST_DONE;
					case (kind_q)
						KIND_FIT: begin
							if ((dom_q != '0) && ((dom_q >> POS_BITS) == '0)) begin
								flag_q  <= 1'b1;
								limit_q <= POS_BITS'(dom_q);
								start_q <= '0;
								stop_q  <= POS_BITS'(dom_q);
								ok_q    <= 1'b1;
							end
						end
						KIND_ZOOM: begin
							if (zoom_ok) begin
								ok_q    <= 1'b1;
								op_q    <= PASS_SCALE;
								mul_q   <= {64'd0, sn_q};
								cnt_q   <= '0;
								state_q <= ST_MUL;
							end
						end
						KIND_PAN: begin
							if (usable) begin
								start_q <= POS_BITS'(pan_nb);
								stop_q  <= POS_BITS'(pan_nb + span64);
								ok_q    <= 1'b1;
							end
						end
						KIND_FOCUS: begin
							if (usable) begin
								start_q <= POS_BITS'(f_st);
								stop_q  <= POS_BITS'(f_sp);
								ok_q    <= 1'b1;
							end
						end
						KIND_CLEAR: begin
							flag_q  <= 1'b0;
							limit_q <= '0;
							start_q <= '0;
							stop_q  <= '0;
							ok_q    <= 1'b1;
						end
						default: begin
						end
					endcase
				end
				ST_MUL: begin
					mul_q <= {mul_sum, mul_q[31:1]};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(MUL_STEPS - 1)) begin
						cnt_q   <= '0;
						rem_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					mul_q <= dv_q;
					rem_q <= dv_r;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(DIV_CYCLES - 1))
						state_q <= ST_POST;
				end
				ST_POST: begin
					cnt_q <= '0;
					case (op_q)
						PASS_SCALE: begin
							ns_q    <= POS_BITS'(ns64);
							op_q    <= PASS_OLD;
							mul_q   <= {64'd0, an_q};
							state_q <= ST_MUL;
						end
						PASS_OLD: begin
							offold_q <= POS_BITS'(mul_q[63:0]);
							op_q     <= PASS_NEW;
							mul_q    <= {64'd0, an_q};
							state_q  <= ST_MUL;
						end
						default: begin
							off_q   <= POS_BITS'(mul_q[63:0]);
							state_q <= ST_ZF1;
						end
					endcase
				end
				ST_ZF1: begin
					anchor_q <= start_q + offold_q;
					lim_q    <= limit_q - ns_q;
					state_q  <= ST_ZF2;
				end
				ST_ZF2: begin
					start_q <= z_nb;
					stop_q  <= z_nb + ns_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!mvalid_q || m_tready) begin
						mvalid_q <= 1'b1;
						mdata_q  <= {64'(stop_q), 64'(start_q), flag_q, ok_q};
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = mvalid_q;
	assign m_tdata  = M_DATA_W'(mdata_q);

endmodule

FILE: src/twzp_checker.sv
// Port-level checker for the timeline window zoom/pan core, with its bind.
// Depends on twzp_pkg and timeline_window_zoom_pan_core.
module twzp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [twzp_pkg::M_DATA_W-1:0] m_tdata
);
	import twzp_pkg::*;

	// A stalled result word must hold.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// The core works on one command at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word taken while busy");

	// A valid window is never empty.
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[65:2] < m_tdata[129:66])
		else $error("valid window is empty");

	// An invalid window always reads as all zero.
	a_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[1] |-> m_tdata[65:2] == '0 && m_tdata[129:66] == '0)
		else $error("invalid window holds stale positions");

endmodule

bind timeline_window_zoom_pan_core twzp_checker u_twzp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
